// ===== design/newreno_congestion_window_controller_top_assert.svh =====
// Assertion macros for the congestion window controller
`ifndef NEWRENO_CONGESTION_WINDOW_CONTROLLER_TOP_ASSERT_SVH
`define NEWRENO_CONGESTION_WINDOW_CONTROLLER_TOP_ASSERT_SVH

// property that holds whenever reset is released
`define NR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked from the cycle after a condition
`define NR_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

// ===== design/nrcc_pkg.sv =====
// ----------------------------------------------------------------------------
// nrcc_pkg
// Shared types and constants of the congestion window controller.
// ----------------------------------------------------------------------------
package nrcc_pkg;
  localparam int NUM_SPACES = 3;
  localparam int SPACE_W = 2;
  localparam logic [31:0] ALL_ONES_32 = 32'hFFFF_FFFF;

  localparam logic [1:0] CFG_INIT_WIN = 2'd0;
  localparam logic [1:0] CFG_MIN_WIN  = 2'd1;
  localparam logic [1:0] CFG_LOSS_FAC = 2'd2;
  localparam logic [1:0] CFG_MAX_DGRAM = 2'd3;

  localparam logic [2:0] ACT_SENT    = 3'd0;
  localparam logic [2:0] ACT_ACKED   = 3'd1;
  localparam logic [2:0] ACT_LOST    = 3'd2;
  localparam logic [2:0] ACT_ECN     = 3'd3;
  localparam logic [2:0] ACT_DISCARD = 3'd4;
  localparam logic [2:0] ACT_CREDIT  = 3'd5;
  localparam logic [2:0] ACT_RESET   = 3'd6;
  localparam logic [2:0] ACT_SPARE   = 3'd7;

  localparam logic [1:0] PH_NONE  = 2'd0;
  localparam logic [1:0] PH_SLOW  = 2'd1;
  localparam logic [1:0] PH_AVOID = 2'd2;
  localparam logic [1:0] PH_RECOV = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_DIV, ST_MUL, ST_DONE, ST_OUT
  } state_t;

  // request to the shared multiply/divide unit
  typedef struct packed {
    logic        start;
    logic        is_div;
    logic [47:0] a;
    logic [31:0] b;
  } md_req_t;

  // res is one bit wider than a: window times a loss factor above one
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [48:0] res;
  } md_rsp_t;
endpackage

// ===== design/nrcc_muldiv.sv =====
// ----------------------------------------------------------------------------
// nrcc_muldiv
// Shared shift-add multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module nrcc_muldiv import nrcc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  md_req_t req,
  output md_rsp_t rsp
);
  logic        busy_r, busy_nxt, done_r, done_nxt, div_r, div_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [48:0] acc_r, acc_nxt;   // product, or quotient bits
  logic [47:0] a_r, a_nxt;
  logic [31:0] b_r, b_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [32:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    rem_nxt  = rem_r;
    trial    = {rem_r[31:0], a_r[47]} - {1'b0, b_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      div_nxt  = req.is_div;
      a_nxt    = req.a;
      b_nxt    = req.b;
      acc_nxt  = '0;
      rem_nxt  = '0;
      cnt_nxt  = 6'd0;
    end else if (busy_r) begin
      if (div_r) begin
        // restoring step on the next dividend bit
        if (!trial[32]) begin
          rem_nxt = trial;
          acc_nxt = {acc_r[47:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[31:0], a_r[47]};
          acc_nxt = {acc_r[47:0], 1'b0};
        end
        a_nxt = {a_r[46:0], 1'b0};
        if (cnt_r == 6'd47) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end else begin
        // multiplier bit from b, lsb first
        if (b_r[0]) acc_nxt = acc_r + ({1'b0, a_r} << cnt_r[4:0]);
        b_nxt = {1'b0, b_r[31:1]};
        if (cnt_r == 6'd16) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
      cnt_nxt = cnt_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      div_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      div_r  <= div_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp = '{busy: busy_r, done: done_r, res: acc_r};

  `include "newreno_congestion_window_controller_top_assert.svh"
  `NR_ASSERT(a_done_not_busy, !(done_r && busy_r), "muldiv done while busy")
  `NR_ASSERT_NEXT(a_start_busy, req.start, busy_r, "muldiv did not start")
  `NR_ASSERT(a_cnt_range, cnt_r <= 6'd48, "muldiv counter overran")
endmodule

// ===== design/newreno_congestion_window_controller_top.sv =====
// ----------------------------------------------------------------------------
// newreno_congestion_window_controller_top
// NewReno congestion window controller with a shared iterative mul/div unit.
// ----------------------------------------------------------------------------
// One packet event is taken per transfer on the in_ channel; exactly one
// result transfer follows on the out_ channel for every event.
// in_tready is high only in the idle state with no result waiting, so one
// event is worked on at a time. Sent, discard, credit, reset, slow start acks
// and most loss/ECN events pass from the exec state through done and out to
// out_tvalid without the unit. An ack in avoidance with a nonzero window uses
// the shared unit as a 48-bit restoring divider (48 steps); a congestion
// event uses it as a 17-step shift-add multiplier.
// The result sits in an output register; while out_tready is low it holds and
// the next event is accepted in the cycle after the result has been taken.
// rst_n (synchronous, active low) loads the reset values of the registers
// and the state: window from the reset value of the start-window register,
// threshold all ones, counts zero. Configuration writes go on cfg_ while idle.
// ----------------------------------------------------------------------------
module newreno_congestion_window_controller_top import nrcc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: byte_count[31:0], tx_time[94:32], now_time[157:95],
  // pkt_num[219:158], largest_lost_time[282:220],
  // pc_duration[345:283], number_space[347:346], ce_count[409:348], pad
  input  logic [415:0] in_tdata,
  input  logic         in_tlast,   // last_in_batch
  input  logic [2:0]   in_tuser,   // action
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: send_credit[31:0], window_bytes[63:32], flight_bytes[95:64],
  // threshold_bytes[127:96]
  output logic [127:0] out_tdata,
  output logic [1:0]   out_tuser   // cc_phase
);
  state_t st_r, st_nxt;

  logic [31:0] init_win_r, min_win_r;
  logic [16:0] loss_fac_r;
  logic [15:0] max_dg_r;

  logic [31:0] win_r, flight_r, ssth_r, extra_r;
  logic [62:0] rec_r;
  logic [61:0] ecn_r [NUM_SPACES];
  logic [61:0] exp_r;
  logic        seen_r, broken_r;

  // latched event
  logic [2:0]  act_r;
  logic [31:0] bytes_r;
  logic [62:0] st_t_r, now_r, largest_r, period_r;
  logic [61:0] pn_r, ce_r;
  logic [1:0]  sp_r;
  logic        last_r;
  logic        collapse_r;
  logic [1:0]  phase_r;
  logic        ovalid_r;
  logic [127:0] odata_r;
  logic [1:0]  ouser_r;

  md_req_t req;
  md_rsp_t rsp;

  nrcc_muldiv u_md (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  assign in_tready  = (st_r == ST_IDLE) && !ovalid_r;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

  wire acc_in = in_tvalid && in_tready;

  // exec-stage decisions
  logic [32:0] fsum;
  logic [32:0] wgrow;
  logic [31:0] fsub;
  logic [63:0] tsum;
  logic        in_period, ack_grow, cong_go, ecn_hit, sp_ok, collapse_go;
  logic [62:0] cong_t;
  always_comb begin
    fsum = {1'b0, flight_r} + {1'b0, bytes_r};
    wgrow = {1'b0, win_r} + {1'b0, bytes_r};
    fsub = (bytes_r > flight_r) ? 32'd0 : flight_r - bytes_r;
    tsum = {1'b0, st_t_r} + {1'b0, period_r};
    in_period = tsum >= {1'b0, largest_r};
    ack_grow = st_t_r > rec_r;
    sp_ok = {30'd0, sp_r} < NUM_SPACES;
    ecn_hit = sp_ok && (ce_r > ecn_r[sp_r[SPACE_W-1:0]]);
    cong_t = (act_r == ACT_LOST) ? largest_r : st_t_r;
    cong_go = ((act_r == ACT_LOST && last_r) || (act_r == ACT_ECN && ecn_hit))
              && (cong_t > rec_r);
    // run state as it stands once this packet has been counted
    collapse_go = in_period ? (!(seen_r && exp_r != pn_r) && !broken_r)
                            : (seen_r && !broken_r);
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (acc_in) st_nxt = ST_EXEC;
      ST_EXEC: begin
        if (act_r == ACT_ACKED && ack_grow && !(win_r < ssth_r) && win_r != 32'd0)
          st_nxt = ST_DIV;
        else if (cong_go) st_nxt = ST_MUL;
        else st_nxt = ST_DONE;
      end
      ST_DIV, ST_MUL: if (rsp.done) st_nxt = ST_DONE;
      ST_DONE: st_nxt = ST_OUT;
      ST_OUT: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // unit request
  always_comb begin
    req = '0;
    if (st_r == ST_EXEC) begin
      if (act_r == ACT_ACKED) begin
        req.start  = ack_grow && !(win_r < ssth_r) && win_r != 32'd0;
        req.is_div = 1'b1;
        req.a      = {32'd0, max_dg_r} * {16'd0, bytes_r};
        req.b      = win_r;
      end else begin
        req.start  = cong_go;
        req.is_div = 1'b0;
        req.a      = {16'd0, win_r};
        req.b      = {15'd0, loss_fac_r};
      end
    end
  end

  wire [32:0] prod_sh = rsp.res[48:16];
  wire [31:0] mul_w = prod_sh[32] ? ALL_ONES_32 : prod_sh[31:0];
  wire [31:0] dec_w = (mul_w < min_win_r) ? min_win_r : mul_w;
  wire [32:0] wsum_q = {1'b0, win_r} +
                       ((rsp.res > {17'd0, ALL_ONES_32}) ? {1'b0, ALL_ONES_32}
                                                         : {1'b0, rsp.res[31:0]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      init_win_r <= 32'd12000;
      min_win_r  <= 32'd2400;
      loss_fac_r <= 17'd32768;
      max_dg_r   <= 16'd1200;
      win_r <= 32'd12000;
      flight_r <= '0;
      ssth_r <= ALL_ONES_32;
      rec_r <= '0;
      for (int i = 0; i < NUM_SPACES; i++) ecn_r[i] <= '0;
      extra_r <= '0;
      exp_r <= '0;
      seen_r <= 1'b0;
      broken_r <= 1'b0;
      ovalid_r <= 1'b0;
      phase_r <= PH_NONE;
      collapse_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_INIT_WIN:  init_win_r <= cfg_wdata;
          CFG_MIN_WIN:   min_win_r  <= cfg_wdata;
          CFG_LOSS_FAC:  loss_fac_r <= cfg_wdata[16:0];
          CFG_MAX_DGRAM: max_dg_r   <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      case (st_r)
        ST_IDLE: phase_r <= PH_NONE;
        ST_EXEC: begin
          collapse_r <= (act_r == ACT_LOST) && last_r && collapse_go;
          case (act_r)
            ACT_SENT: begin
              if (extra_r != 32'd0) extra_r <= extra_r - 32'd1;
              flight_r <= fsum[32] ? ALL_ONES_32 : fsum[31:0];
            end
            ACT_ACKED: begin
              flight_r <= fsub;
              if (ack_grow) begin
                if (win_r < ssth_r) begin
                  win_r <= wgrow[32] ? ALL_ONES_32 : wgrow[31:0];
                  phase_r <= PH_SLOW;
                end else begin
                  phase_r <= PH_AVOID;
                  if (win_r == 32'd0) win_r <= ALL_ONES_32;
                end
              end
            end
            ACT_LOST: begin
              flight_r <= fsub;
              if (last_r) begin
                seen_r <= 1'b0;
                broken_r <= 1'b0;
                exp_r <= '0;
              end else if (in_period) begin
                if (seen_r && exp_r != pn_r) broken_r <= 1'b1;
                seen_r <= 1'b1;
                exp_r <= pn_r + 62'd1;
              end
            end
            ACT_ECN: if (ecn_hit) ecn_r[sp_r[SPACE_W-1:0]] <= ce_r;
            ACT_DISCARD: flight_r <= fsub;
            ACT_CREDIT: if (extra_r != ALL_ONES_32) extra_r <= extra_r + 32'd1;
            ACT_RESET: begin
              win_r <= init_win_r;
              flight_r <= '0;
              ssth_r <= ALL_ONES_32;
              rec_r <= '0;
              for (int i = 0; i < NUM_SPACES; i++) ecn_r[i] <= '0;
              exp_r <= '0;
              seen_r <= 1'b0;
              broken_r <= 1'b0;
            end
            default: ;
          endcase
          if (cong_go) begin
            rec_r <= now_r;
            phase_r <= PH_RECOV;
          end
        end
        ST_DIV: if (rsp.done) win_r <= wsum_q[32] ? ALL_ONES_32 : wsum_q[31:0];
        ST_MUL: if (rsp.done) begin
          win_r  <= dec_w;
          ssth_r <= dec_w;
        end
        ST_DONE: if (collapse_r) win_r <= min_win_r;
        ST_OUT: begin
          ovalid_r <= 1'b1;
          ouser_r <= phase_r;
          odata_r <= {ssth_r, flight_r, win_r,
                      (extra_r != 32'd0) ? ALL_ONES_32 :
                      (flight_r < win_r ? win_r - flight_r : 32'd0)};
        end
        default: ;
      endcase
    end
    if (acc_in) begin
      act_r     <= in_tuser;
      bytes_r   <= in_tdata[31:0];
      st_t_r    <= in_tdata[94:32];
      now_r     <= in_tdata[157:95];
      pn_r      <= in_tdata[219:158];
      largest_r <= in_tdata[282:220];
      period_r  <= in_tdata[345:283];
      sp_r      <= in_tdata[347:346];
      ce_r      <= in_tdata[409:348];
      last_r    <= in_tlast;
    end
  end

  `include "newreno_congestion_window_controller_top_assert.svh"
  `NR_ASSERT(a_busy_no_ready, !(st_r != ST_IDLE && in_tready), "ready while busy")
  `NR_ASSERT_NEXT(a_out_once, st_r == ST_OUT, ovalid_r, "result not raised")
  `NR_ASSERT(a_unit_owned, !(rsp.busy && st_r != ST_DIV && st_r != ST_MUL),
             "unit busy outside its states")
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the NewReno congestion window controller: packet
// events go in on the in_ stream, a predictor tracks window, flight and
// threshold, and every result transfer is compared with the oldest
// expectation. Several register settings are run, with bursty input and a
// stalling receiver.
// ----------------------------------------------------------------------------
module testbench;
  import nrcc_pkg::*;

  localparam longint unsigned M32 = 64'hFFFF_FFFF;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int NUM_PHASES = 5;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [2:0]  act;
    logic [31:0] bytes;
    logic [62:0] sent;
    logic [62:0] now;
    logic [61:0] pn;
    logic        last;
    logic [62:0] largest;
    logic [62:0] period;
    logic [1:0]  space;
    logic [61:0] ce;
  } pkt_event_t;

  typedef struct {
    logic [31:0] credit;
    logic [31:0] win;
    logic [31:0] flight;
    logic [31:0] thresh;
    logic [1:0]  phase;
  } cc_result_t;

  class window_scoreboard;
    logic [31:0] init_win, min_win, thresh, win, flight, extra;
    logic [16:0] factor;
    logic [15:0] dgram;
    logic [62:0] rec_start;
    logic [61:0] ecn [NUM_SPACES];
    logic [61:0] next_pn;
    logic        run_seen, run_broken;
    cc_result_t  pending [$];
    int          errors;

    function new();
      init_win = 12000;
      min_win = 2400;
      factor = 32768;
      dgram = 1200;
      extra = 0;
      errors = 0;
      restart();
    endfunction

    function void restart();
      win = init_win;
      flight = 0;
      thresh = ALL_ONES_32;
      rec_start = 0;
      foreach (ecn[i]) ecn[i] = 0;
      next_pn = 0;
      run_seen = 0;
      run_broken = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        CFG_INIT_WIN:  init_win = v;
        CFG_MIN_WIN:   min_win = v;
        CFG_LOSS_FAC:  factor = v[16:0];
        CFG_MAX_DGRAM: dgram = v[15:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] sat(longint unsigned v);
      return (v > M32) ? ALL_ONES_32 : v[31:0];
    endfunction

    function void flight_drop(logic [31:0] b);
      flight = (b > flight) ? 32'd0 : flight - b;
    endfunction

    function bit congest(logic [62:0] t, logic [62:0] now);
      longint unsigned w;
      if (t <= rec_start) return 0;
      rec_start = now;
      w = (64'(win) * 64'(factor)) >> 16;
      if (w > M32) w = M32;
      if (w < 64'(min_win)) w = 64'(min_win);
      win = w[31:0];
      thresh = w[31:0];
      return 1;
    endfunction

    function void note_event(pkt_event_t e);
      cc_result_t r;
      longint unsigned q;
      r.phase = PH_NONE;
      case (e.act)
        ACT_SENT: begin
          if (extra != 0) extra--;
          flight = sat(64'(flight) + 64'(e.bytes));
        end
        ACT_ACKED: begin
          flight_drop(e.bytes);
          if (e.sent > rec_start) begin
            if (win < thresh) begin
              win = sat(64'(win) + 64'(e.bytes));
              r.phase = PH_SLOW;
            end else begin
              q = (win == 0) ? M32 : (64'(dgram) * 64'(e.bytes)) / 64'(win);
              win = sat(64'(win) + q);
              r.phase = PH_AVOID;
            end
          end
        end
        ACT_LOST: begin
          flight_drop(e.bytes);
          if (64'(e.sent) + 64'(e.period) >= 64'(e.largest)) begin
            if (run_seen && next_pn != e.pn) run_broken = 1;
            run_seen = 1;
            next_pn = e.pn + 62'd1;
          end
          if (e.last) begin
            if (congest(e.largest, e.now)) r.phase = PH_RECOV;
            if (run_seen && !run_broken) win = min_win;
            run_seen = 0;
            run_broken = 0;
            next_pn = 0;
          end
        end
        ACT_ECN: begin
          if (e.space < NUM_SPACES) begin
            if (e.ce > ecn[e.space]) begin
              ecn[e.space] = e.ce;
              if (congest(e.sent, e.now)) r.phase = PH_RECOV;
            end
          end
        end
        ACT_DISCARD: flight_drop(e.bytes);
        ACT_CREDIT: if (extra != ALL_ONES_32) extra++;
        ACT_RESET: restart();
        default: ;
      endcase
      r.credit = (extra != 0) ? ALL_ONES_32 : ((flight < win) ? win - flight : 32'd0);
      r.win = win;
      r.flight = flight;
      r.thresh = thresh;
      pending.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
    endtask

    task check_result(logic [127:0] d, logic [1:0] u);
      cc_result_t r;
      if (pending.size() == 0) begin
        report("unexpected result", d[31:0], 32'd0);
        return;
      end
      r = pending.pop_front();
      if (d[31:0] !== r.credit) report("send_credit", d[31:0], r.credit);
      if (d[63:32] !== r.win) report("window_bytes", d[63:32], r.win);
      if (d[95:64] !== r.flight) report("flight_bytes", d[95:64], r.flight);
      if (d[127:96] !== r.thresh) report("threshold_bytes", d[127:96], r.thresh);
      if (u !== r.phase) report("cc_phase", 32'(u), 32'(r.phase));
    endtask
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         cfg_we = 0;
  logic [1:0]   cfg_index = 0;
  logic [31:0]  cfg_wdata = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [415:0] in_tdata = '0;
  logic         in_tlast = 0;
  logic [2:0]   in_tuser = 0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [127:0] out_tdata;
  logic [1:0]   out_tuser;

  window_scoreboard sb = new();

  logic [62:0] t_now = 1000;
  logic [61:0] ce_seen [NUM_SPACES];
  int burst_left = 0;
  int hold_gen = 0;
  int hold_seen = 0;

  newreno_congestion_window_controller_top dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: its own stall pattern, plus a long hold-off on request
  initial begin
    int cyc;
    int hold;
    cyc = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_gen != hold_seen) begin
        hold_seen = hold_gen;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        out_tready = 0;
      end else begin
        case ((cyc / 256) % 4)
          0: out_tready = 1;
          1: out_tready = ($urandom_range(0, 3) != 0);
          2: out_tready = ((cyc % 7) < 3);
          default: out_tready = 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);

  task automatic send_event(pkt_event_t e);
    int gap;
    @(negedge clk);
    in_tvalid = 1;
    in_tuser = e.act;
    in_tlast = e.last;
    in_tdata = {6'd0, e.ce, e.space, e.period, e.largest, e.pn, e.now, e.sent, e.bytes};
    do @(posedge clk); while (!in_tready);
    sb.note_event(e);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 15);
      @(negedge clk);
      in_tvalid = 0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  task automatic drain();
    int n;
    @(negedge clk);
    in_tvalid = 0;
    n = 0;
    while ((sb.pending.size() != 0) && (n < 20000)) begin
      @(posedge clk);
      n++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] v);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_wdata = v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we = 0;
  endtask

  function automatic pkt_event_t blank(logic [2:0] act);
    pkt_event_t e;
    e.act = act;
    e.bytes = $urandom_range(1, 1500);
    e.sent = t_now;
    e.now = t_now;
    e.pn = 62'({$urandom, $urandom});
    e.last = 0;
    e.largest = 63'({$urandom, $urandom});
    e.period = 63'({$urandom, $urandom});
    e.space = 2'($urandom_range(0, 3));
    e.ce = 62'({$urandom, $urandom});
    return e;
  endfunction

  function automatic logic [62:0] recent(int span);
    int d;
    d = $urandom_range(0, span);
    return (t_now > 63'(d)) ? t_now - 63'(d) : 63'd0;
  endfunction

  // well-formed loss run, mostly contiguous numbers, optional gap
  task automatic loss_batch();
    pkt_event_t e;
    int n;
    logic [61:0] pn;
    logic [62:0] period, tstamp [8];
    n = $urandom_range(1, 5);
    pn = ($urandom_range(0, 9) == 0) ? 62'h3FFF_FFFF_FFFF_FFFE : 62'($urandom_range(0, 5000));
    period = 63'($urandom_range(0, 400));
    for (int i = 0; i < n; i++) tstamp[i] = recent(300) - 63'((n - i) * 20);
    for (int i = 0; i < n; i++) begin
      e = blank(ACT_LOST);
      e.sent = tstamp[i];
      e.pn = pn;
      e.last = (i == n - 1);
      e.largest = tstamp[n - 1];
      e.period = period;
      e.now = t_now;
      e.bytes = $urandom_range(0, 1500);
      send_event(e);
      pn = pn + (($urandom_range(0, 4) == 0) ? 62'd2 : 62'd1);
      t_now += 63'd1;
    end
  endtask

  task automatic random_item();
    pkt_event_t e;
    int pick;
    pick = $urandom_range(0, 99);
    t_now += 63'($urandom_range(1, 40));
    if (pick < 30) begin
      e = blank(ACT_SENT);
    end else if (pick < 62) begin
      e = blank(ACT_ACKED);
      e.sent = recent(400);
    end else if (pick < 72) begin
      loss_batch();
      return;
    end else if (pick < 76) begin
      e = blank(ACT_LOST);
      e.last = 1'($urandom_range(0, 1));
    end else if (pick < 84) begin
      e = blank(ACT_ECN);
      e.space = 2'($urandom_range(0, 3));
      e.sent = recent(400);
      if (e.space < NUM_SPACES) begin
        ce_seen[e.space] += 62'($urandom_range(0, 3));
        e.ce = ce_seen[e.space];
      end
    end else if (pick < 90) begin
      e = blank(ACT_DISCARD);
    end else if (pick < 94) begin
      e = blank(ACT_CREDIT);
    end else if (pick < 97) begin
      e = blank(ACT_RESET);
      foreach (ce_seen[i]) ce_seen[i] = 0;
    end else begin
      e = blank(ACT_SPARE);
    end
    if ($urandom_range(0, 19) == 0) e.bytes = $urandom;
    send_event(e);
  endtask

  task automatic directed();
    pkt_event_t e;
    e = blank(ACT_SENT); e.bytes = ALL_ONES_32; send_event(e);
    e = blank(ACT_SENT); e.bytes = 32'd5; send_event(e);
    e = blank(ACT_DISCARD); e.bytes = ALL_ONES_32; send_event(e);
    e = blank(ACT_DISCARD); e.bytes = 0; send_event(e);
    e = blank(ACT_SENT); e.bytes = 3000; send_event(e);
    e = blank(ACT_ACKED); e.sent = 0; e.bytes = 1000; send_event(e);
    e = blank(ACT_ACKED); e.sent = 10; e.bytes = 1200; send_event(e);
    // loss run that wraps the packet number through zero
    e = blank(ACT_LOST); e.pn = '1; e.sent = 100; e.largest = 120; e.period = 50;
    e.bytes = 0; send_event(e);
    e.pn = 0; e.sent = 120; e.last = 1; e.now = 500; send_event(e);
    e = blank(ACT_ACKED); e.sent = 600; e.bytes = 1200; send_event(e);
    e = blank(ACT_ECN); e.space = 3; e.ce = '1; e.sent = '1; send_event(e);
    e = blank(ACT_ECN); e.space = 1; e.ce = 5; e.sent = 700; e.now = 800; send_event(e);
    e = blank(ACT_ECN); e.space = 1; e.ce = 5; e.sent = 900; send_event(e);
    e = blank(ACT_CREDIT); send_event(e);
    e = blank(ACT_CREDIT); send_event(e);
    e = blank(ACT_SENT); send_event(e);
    e = blank(ACT_SPARE); send_event(e);
    e = blank(ACT_LOST); e.pn = '1; e.sent = '1; e.largest = '1; e.period = '1;
    e.now = '1; e.last = 1; e.bytes = ALL_ONES_32; send_event(e);
    e = blank(ACT_ECN); e.space = 2; e.ce = '1; e.sent = '1; e.now = '1; send_event(e);
    e = blank(ACT_ACKED); e.sent = '1; send_event(e);
    e = blank(ACT_RESET); send_event(e);
    e = blank(ACT_SENT); e.bytes = 0; send_event(e);
  endtask

  initial begin
    logic [31:0] settings [NUM_PHASES][4];
    pkt_event_t e;
    settings[0] = '{32'd12000, 32'd2400, 32'd32768, 32'd1200};
    settings[1] = '{32'hFFFF_FFFF, 32'd0, 32'd65536, 32'd65535};
    settings[2] = '{32'd0, 32'd0, 32'd0, 32'd1};
    settings[3] = '{32'd5000, 32'hFFFF_FFFF, 32'd45875, 32'd1500};
    settings[4] = '{32'd20000, 32'd1000, 32'd16384, 32'd9000};
    foreach (ce_seen[i]) ce_seen[i] = 0;
    repeat (12) @(negedge clk);
    rst_n = 1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int r = 0; r < 4; r++) cfg_write(2'(r), settings[p][r]);
      // new initial window only takes effect through a reset event
      e = blank(ACT_RESET);
      send_event(e);
      foreach (ce_seen[i]) ce_seen[i] = 0;
      t_now = 1000;
      if (p == 0) directed();
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 2 && i == 50) begin
          hold_gen++;
          burst_left = 40;
        end
        random_item();
      end
      drain();
    end
    if (sb.pending.size() != 0) sb.report("results missing", 32'(sb.pending.size()), 32'd0);
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+design
design/nrcc_pkg.sv
design/nrcc_muldiv.sv
design/newreno_congestion_window_controller_top.sv
tb/testbench.sv
